FILE: rtl/csvs_pkg.sv
// ----------------------------------------------------------------------------
// csvs_pkg
// Shared types, constants and helpers of the CSV record splitter.
// ----------------------------------------------------------------------------
package csvs_pkg;

    // trailing whitespace buffer
    localparam int SPACE_DEPTH = 16;
    localparam int SPACE_IDX_W = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
    localparam int SPACE_CNT_W = $clog2(SPACE_DEPTH + 1);

    // physical line counter
    localparam int LINE_BITS = 24;

    // op queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // byte codes
    localparam logic [7:0] BOM_0         = 8'hEF;
    localparam logic [7:0] BOM_1         = 8'hBB;
    localparam logic [7:0] BOM_2         = 8'hBF;
    localparam logic [7:0] QUOTE_CH      = 8'h22;
    localparam logic [7:0] LINE_END      = 8'h0A;
    localparam logic [7:0] DELIM_RESET   = 8'd44;
    localparam logic [7:0] COMMENT_RESET = 8'd35;

    // configuration register indexes
    localparam logic CFG_DELIMITER    = 1'b0;
    localparam logic CFG_COMMENT_MARK = 1'b1;

    // done status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_HEADER = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_EOI  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic       last;       // final op of its input item
    } t_op;

    typedef struct packed {
        logic [7:0]           out_byte;
        logic                 has_byte;
        logic                 end_of_cell;
        logic                 end_of_row;
        logic                 header_row;
        logic [LINE_BITS-1:0] line_number;
        logic                 done_res;
        logic [1:0]           status;
    } t_res;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

FILE: rtl/csvs_front.sv
// ----------------------------------------------------------------------------
// csvs_front
// Input side: strips a leading byte order mark, replays the bytes of a
// partial mark as ordinary bytes, and queues one op per byte to the back.
// ----------------------------------------------------------------------------
module csvs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_kind,
    input  logic [7:0]    i_data_byte,
    output logic          o_push,
    output csvs_pkg::t_op o_op,
    input  logic          i_full
);
    import csvs_pkg::*;

    logic       r_at_start;
    logic [1:0] r_bom_pos;
    logic       r_rel_idx;

    logic bom_match;
    logic rel_active;
    logic accept;
    logic rel_done;

    always_comb begin
        bom_match = (t_kind'(i_kind) == KIND_DATA) &&
                    (((r_bom_pos == 2'd0) && (i_data_byte == BOM_0)) ||
                     ((r_bom_pos == 2'd1) && (i_data_byte == BOM_1)) ||
                     ((r_bom_pos == 2'd2) && (i_data_byte == BOM_2)));
        // replay held mark bytes before the item that broke the mark
        rel_active = i_in_valid && r_at_start && !bom_match && (r_bom_pos != 2'd0);
        rel_done   = (({1'b0, r_rel_idx} + 2'd1) == r_bom_pos);

        if (!r_at_start) begin
            o_in_ready = !i_full;
        end else if (bom_match) begin
            o_in_ready = 1'b1;
        end else if (r_bom_pos == 2'd0) begin
            o_in_ready = !i_full;
        end else begin
            o_in_ready = 1'b0;
        end
        accept = i_in_valid && o_in_ready;

        if (rel_active) begin
            o_push         = !i_full;
            o_op.kind      = KIND_DATA;
            o_op.data_byte = r_rel_idx ? BOM_1 : BOM_0;
            o_op.last      = 1'b0;
        end else begin
            o_push         = accept && !(r_at_start && bom_match);
            o_op.kind      = t_kind'(i_kind);
            o_op.data_byte = i_data_byte;
            o_op.last      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_bom_pos  <= 2'd0;
            r_rel_idx  <= 1'b0;
        end else if (rel_active && !i_full) begin
            if (rel_done) begin
                r_at_start <= 1'b0;
                r_bom_pos  <= 2'd0;
                r_rel_idx  <= 1'b0;
            end else begin
                r_rel_idx  <= 1'b1;
            end
        end else if (accept) begin
            if (t_kind'(i_kind) == KIND_EOI) begin
                // next byte starts a new file
                r_at_start <= 1'b1;
                r_bom_pos  <= 2'd0;
            end else if (r_at_start && bom_match) begin
                if (r_bom_pos == 2'd2) begin
                    r_bom_pos  <= 2'd0;
                    r_at_start <= 1'b0;
                end else begin
                    r_bom_pos  <= r_bom_pos + 2'd1;
                end
            end else begin
                r_at_start <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/csvs_fifo.sv
// ----------------------------------------------------------------------------
// csvs_fifo
// Short op queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module csvs_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  csvs_pkg::t_op i_op,
    output logic          o_full,
    output logic          o_valid,
    output csvs_pkg::t_op o_op,
    input  logic          i_pop
);
    import csvs_pkg::*;

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    always_comb begin
        o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
        o_valid = (r_cnt != '0);
        o_op    = r_mem[r_rd];
        do_push = i_push && !o_full;
        do_pop  = i_pop && o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (do_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

endmodule

FILE: rtl/csvs_back.sv
// ----------------------------------------------------------------------------
// csvs_back
// Cell engine: line, quote and trim state, trailing whitespace buffer,
// one-result holding stage that resolves last_of_run, and output register.
// ----------------------------------------------------------------------------
module csvs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_delimiter,
    input  logic [7:0]     i_comment_mark,
    input  logic           i_op_valid,
    input  csvs_pkg::t_op  i_op,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output csvs_pkg::t_res o_res,
    output logic           o_last
);
    import csvs_pkg::*;

    localparam logic [7:0]           UPPER_A     = 8'h41;
    localparam logic [7:0]           UPPER_Z     = 8'h5A;
    localparam logic [7:0]           CASE_OFFSET = 8'h20;
    localparam logic [LINE_BITS-1:0] LINE_MAX    = {LINE_BITS{1'b1}};

    typedef enum logic [1:0] {
        PH_START,
        PH_SKIP,
        PH_HEADER,
        PH_DATA
    } t_phase;

    typedef enum logic [2:0] {
        A_NONE,
        A_LINE_END,
        A_CELL_END,
        A_WS_STORE,
        A_WS_DROP,
        A_BYTE,
        A_FLUSH
    } t_act;

    typedef enum logic [1:0] {
        S_RUN,
        S_FLUSH,
        S_DONE
    } t_state;

    // state
    t_state               r_state,      n_state;
    t_phase               r_phase,      n_phase;
    logic                 r_inq,        n_inq;
    logic                 r_qp,         n_qp;
    logic                 r_has,        n_has;
    logic [SPACE_CNT_W-1:0] r_cnt,      n_cnt;
    logic                 r_hdr_seen,   n_hdr_seen;
    logic [LINE_BITS-1:0] r_line,       n_line;
    logic                 r_ovf,        n_ovf;
    logic [SPACE_CNT_W-1:0] r_fidx,     n_fidx;
    logic [7:0]           r_pend_byte,  n_pend_byte;
    logic                 r_pend_last,  n_pend_last;
    logic [7:0]           r_buf [SPACE_DEPTH];
    // holding stage and output register
    logic                 r_hold_v,     n_hold_v;
    logic                 r_hold_last,  n_hold_last;
    t_res                 r_hold,       n_hold;
    logic                 r_out_valid,  n_out_valid;
    logic                 r_out_last,   n_out_last;
    t_res                 r_out_res,    n_out_res;

    // feed decode
    logic [7:0] c;
    logic       c_ws;
    t_phase     d_phase;
    logic       d_inq;
    logic       d_qp;
    logic       d_hs;
    logic       d_go;
    logic       d_unq;
    logic       d_content;
    t_act       d_act;
    logic [7:0] d_byte;

    // engine
    logic                 out_free;
    logic                 can_emit;
    logic                 eng_emit;
    logic                 eng_last;
    logic                 eng_end;
    t_res                 eng_res;
    logic                 hold_out;
    logic                 buf_we;
    logic                 need_emit;
    logic                 row_open;
    logic [LINE_BITS-1:0] line_num;
    logic [1:0]           done_status;

    always_comb begin
        c         = i_op.data_byte;
        c_ws      = is_ws(c);
        d_phase   = r_phase;
        d_inq     = r_inq;
        d_qp      = r_qp;
        d_hs      = r_hdr_seen;
        d_go      = 1'b0;
        d_unq     = 1'b0;
        d_content = 1'b0;
        d_act     = A_NONE;

        if (c == LINE_END) begin
            d_act = A_LINE_END;
        end else if (r_phase != PH_SKIP) begin
            d_go = 1'b1;
            if (r_phase == PH_START) begin
                if (c_ws && (c != i_delimiter)) begin
                    d_go = 1'b0;
                end else if (c == i_comment_mark) begin
                    d_phase = PH_SKIP;
                    d_go    = 1'b0;
                end else begin
                    d_phase = r_hdr_seen ? PH_DATA : PH_HEADER;
                    d_hs    = 1'b1;
                end
            end
            if (d_go) begin
                if (r_inq) begin
                    if (r_qp) begin
                        d_qp = 1'b0;
                        if (c == QUOTE_CH) begin
                            d_content = 1'b1;
                        end else begin
                            d_inq = 1'b0;
                            d_unq = 1'b1;
                        end
                    end else if (c == QUOTE_CH) begin
                        d_qp = 1'b1;
                    end else begin
                        d_content = 1'b1;
                    end
                end else begin
                    d_unq = 1'b1;
                end
                if (d_unq) begin
                    if (c == QUOTE_CH) begin
                        d_inq = 1'b1;
                    end else if (c == i_delimiter) begin
                        d_act = A_CELL_END;
                    end else begin
                        d_content = 1'b1;
                    end
                end
            end
        end

        if (d_content) begin
            if (c_ws) begin
                if (!r_has) begin
                    d_act = A_NONE;
                end else if (r_cnt < SPACE_CNT_W'(SPACE_DEPTH)) begin
                    d_act = A_WS_STORE;
                end else begin
                    d_act = A_WS_DROP;
                end
            end else begin
                d_act = (r_cnt != '0) ? A_FLUSH : A_BYTE;
            end
        end

        if ((d_phase == PH_HEADER) && (c >= UPPER_A) && (c <= UPPER_Z)) begin
            d_byte = c + CASE_OFFSET;
        end else begin
            d_byte = c;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_inq       = r_inq;
        n_qp        = r_qp;
        n_has       = r_has;
        n_cnt       = r_cnt;
        n_hdr_seen  = r_hdr_seen;
        n_line      = r_line;
        n_ovf       = r_ovf;
        n_fidx      = r_fidx;
        n_pend_byte = r_pend_byte;
        n_pend_last = r_pend_last;

        out_free    = !r_out_valid || i_out_ready;
        can_emit    = !r_hold_v || out_free;
        line_num    = (r_line == LINE_MAX) ? r_line : r_line + 1'b1;
        row_open    = (r_phase == PH_HEADER) || (r_phase == PH_DATA);
        done_status = !r_hdr_seen ? STATUS_NO_HEADER :
                      (r_ovf ? STATUS_OVERFLOW : STATUS_OK);

        eng_emit    = 1'b0;
        eng_last    = 1'b0;
        eng_end     = 1'b0;
        eng_res     = '0;
        eng_res.line_number = line_num;
        o_pop       = 1'b0;
        buf_we      = 1'b0;
        need_emit   = 1'b0;

        unique case (r_state)
            S_RUN: begin
                if (i_op_valid) begin
                    if (i_op.kind == KIND_EOI) begin
                        if (can_emit) begin
                            o_pop    = 1'b1;
                            eng_emit = 1'b1;
                            n_inq    = 1'b0;
                            n_qp     = 1'b0;
                            n_has    = 1'b0;
                            n_cnt    = '0;
                            n_phase  = PH_START;
                            if (row_open) begin
                                // close the open row, then report done
                                eng_res.end_of_cell = 1'b1;
                                eng_res.end_of_row  = 1'b1;
                                eng_res.header_row  = (r_phase == PH_HEADER);
                                n_state             = S_DONE;
                            end else begin
                                eng_last            = 1'b1;
                                eng_res.done_res    = 1'b1;
                                eng_res.status      = done_status;
                                eng_res.line_number = '0;
                                n_hdr_seen          = 1'b0;
                                n_line              = '0;
                                n_ovf               = 1'b0;
                            end
                        end
                    end else begin
                        need_emit = ((d_act == A_LINE_END) && row_open) ||
                                    (d_act == A_CELL_END) || (d_act == A_BYTE);
                        if (!need_emit || can_emit) begin
                            o_pop      = 1'b1;
                            n_phase    = d_phase;
                            n_inq      = d_inq;
                            n_qp       = d_qp;
                            n_hdr_seen = d_hs;
                            eng_emit   = need_emit;
                            eng_last   = i_op.last;
                            eng_end    = i_op.last && !need_emit && (d_act != A_FLUSH);
                            eng_res.header_row = (d_phase == PH_HEADER);
                            case (d_act)
                                A_LINE_END: begin
                                    eng_res.end_of_cell = 1'b1;
                                    eng_res.end_of_row  = 1'b1;
                                    eng_res.header_row  = (r_phase == PH_HEADER);
                                    n_inq   = 1'b0;
                                    n_qp    = 1'b0;
                                    n_has   = 1'b0;
                                    n_cnt   = '0;
                                    n_phase = PH_START;
                                    n_line  = line_num;
                                end
                                A_CELL_END: begin
                                    eng_res.end_of_cell = 1'b1;
                                    n_cnt = '0;
                                    n_has = 1'b0;
                                end
                                A_WS_STORE: begin
                                    buf_we = 1'b1;
                                    n_cnt  = r_cnt + 1'b1;
                                end
                                A_WS_DROP: begin
                                    n_ovf = 1'b1;
                                end
                                A_BYTE: begin
                                    eng_res.out_byte = d_byte;
                                    eng_res.has_byte = 1'b1;
                                    n_has            = 1'b1;
                                end
                                A_FLUSH: begin
                                    // replay held whitespace before this byte
                                    n_pend_byte = d_byte;
                                    n_pend_last = i_op.last;
                                    n_fidx      = '0;
                                    n_state     = S_FLUSH;
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
            end
            S_FLUSH: begin
                eng_res.header_row = (r_phase == PH_HEADER);
                eng_res.has_byte   = 1'b1;
                if (can_emit) begin
                    eng_emit = 1'b1;
                    if (r_fidx == r_cnt) begin
                        eng_res.out_byte = r_pend_byte;
                        eng_last         = r_pend_last;
                        n_cnt            = '0;
                        n_has            = 1'b1;
                        n_state          = S_RUN;
                    end else begin
                        eng_res.out_byte = r_buf[r_fidx[SPACE_IDX_W-1:0]];
                        n_fidx           = r_fidx + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (can_emit) begin
                    eng_emit            = 1'b1;
                    eng_last            = 1'b1;
                    eng_res.done_res    = 1'b1;
                    eng_res.status      = done_status;
                    eng_res.line_number = '0;
                    n_hdr_seen          = 1'b0;
                    n_line              = '0;
                    n_ovf               = 1'b0;
                    n_state             = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase

        // hold one result until it is known whether it ends its item
        hold_out    = r_hold_v && out_free && (r_hold_last || eng_emit);
        n_hold      = r_hold;
        n_hold_v    = r_hold_v;
        n_hold_last = r_hold_last;
        if (eng_emit) begin
            n_hold      = eng_res;
            n_hold_v    = 1'b1;
            n_hold_last = eng_last;
        end else if (hold_out) begin
            n_hold_v    = 1'b0;
        end else if (eng_end && r_hold_v) begin
            n_hold_last = 1'b1;
        end

        n_out_res  = r_out_res;
        n_out_last = r_out_last;
        if (hold_out) begin
            n_out_valid = 1'b1;
            n_out_res   = r_hold;
            n_out_last  = r_hold_last;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end

        o_out_valid = r_out_valid;
        o_res       = r_out_res;
        o_last      = r_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_phase     <= PH_START;
            r_inq       <= 1'b0;
            r_qp        <= 1'b0;
            r_has       <= 1'b0;
            r_cnt       <= '0;
            r_hdr_seen  <= 1'b0;
            r_line      <= '0;
            r_ovf       <= 1'b0;
            r_fidx      <= '0;
            r_pend_last <= 1'b0;
            r_hold_v    <= 1'b0;
            r_hold_last <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_inq       <= n_inq;
            r_qp        <= n_qp;
            r_has       <= n_has;
            r_cnt       <= n_cnt;
            r_hdr_seen  <= n_hdr_seen;
            r_line      <= n_line;
            r_ovf       <= n_ovf;
            r_fidx      <= n_fidx;
            r_pend_last <= n_pend_last;
            r_hold_v    <= n_hold_v;
            r_hold_last <= n_hold_last;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
        end
        r_pend_byte <= n_pend_byte;
        r_hold      <= n_hold;
        r_out_res   <= n_out_res;
        if (buf_we) begin
            r_buf[r_cnt[SPACE_IDX_W-1:0]] <= c;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= SPACE_CNT_W'(SPACE_DEPTH))
        else $error("space count beyond buffer depth");

    a_flush_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> (r_fidx <= r_cnt))
        else $error("flush index past held whitespace");

    a_qp_in_quotes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qp |-> r_inq)
        else $error("pending quote outside a quoted span");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.done_res) |-> r_out_last)
        else $error("done result not flagged last of run");

    a_hold_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold_v && !r_hold_last && !eng_emit) |=> r_hold_v)
        else $error("held result lost");

endmodule

FILE: rtl/csv_record_splitter_unit.sv
// ----------------------------------------------------------------------------
// csv_record_splitter_unit
// Streaming CSV cell splitter with quoted fields, trimming and header marking.
// ----------------------------------------------------------------------------
// Usage: feed one file byte per transfer (kind 0) and close the file with an
// end-of-input transfer (kind 1); the block emits cell bytes with end-of-cell
// and end-of-row markers, then one done result carrying status. A byte that
// follows held trailing whitespace in a cell (at most 16 bytes held) is taken
// first, then the held whitespace is replayed one entry per cycle unless the
// output stalls, then the byte itself leaves. End of input with a row open
// first closes the row, then gives the done result. The bytes of a broken
// partial byte order mark are queued again as ordinary bytes before the item
// that broke the mark. Every result passes through a one-entry holding stage,
// so it leaves once the next result exists or its input item is fully worked;
// last_of_run marks the last result of each input transfer. A four-entry op
// queue separates input and engine.
// Write configuration only while the block is idle; a write takes effect at
// once.
// ----------------------------------------------------------------------------
module csv_record_splitter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_kind,
    input  logic [7:0]                     i_data_byte,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_out_byte,
    output logic                           o_has_byte,
    output logic                           o_end_of_cell,
    output logic                           o_end_of_row,
    output logic                           o_header_row,
    output logic [csvs_pkg::LINE_BITS-1:0] o_line_number,
    output logic                           o_done_res,
    output logic [1:0]                     o_status,
    output logic                           o_last_of_run
);
    import csvs_pkg::*;

    logic [7:0] r_delimiter;
    logic [7:0] r_comment_mark;

    logic q_push;
    t_op  q_in_op;
    logic q_full;
    logic q_valid;
    t_op  q_op;
    logic q_pop;
    t_res out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delimiter    <= DELIM_RESET;
            r_comment_mark <= COMMENT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DELIMITER:    r_delimiter    <= i_cfg_data;
                CFG_COMMENT_MARK: r_comment_mark <= i_cfg_data;
                default:          r_delimiter    <= r_delimiter;
            endcase
        end
    end

    csvs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .o_push      (q_push),
        .o_op        (q_in_op),
        .i_full      (q_full)
    );

    csvs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (q_pop)
    );

    csvs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_delimiter    (r_delimiter),
        .i_comment_mark (r_comment_mark),
        .i_op_valid     (q_valid),
        .i_op           (q_op),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_res          (out_res),
        .o_last         (o_last_of_run)
    );

    assign o_out_byte    = out_res.out_byte;
    assign o_has_byte    = out_res.has_byte;
    assign o_end_of_cell = out_res.end_of_cell;
    assign o_end_of_row  = out_res.end_of_row;
    assign o_header_row  = out_res.header_row;
    assign o_line_number = out_res.line_number;
    assign o_done_res    = out_res.done_res;
    assign o_status      = out_res.status;

endmodule

FILE: tb/csv_record_splitter_checker.sv
// ----------------------------------------------------------------------------
// csv_record_splitter_checker
// Watches both channels of the CSV record splitter, keeps its own copy of the
// splitter state and registers, predicts the cell results of every input
// transfer and compares each result transfer field by field, oldest first.
// ----------------------------------------------------------------------------
module csv_record_splitter_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_kind,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [7:0]                     i_out_byte,
    input  logic                           i_has_byte,
    input  logic                           i_end_of_cell,
    input  logic                           i_end_of_row,
    input  logic                           i_header_row,
    input  logic [csvs_pkg::LINE_BITS-1:0] i_line_number,
    input  logic                           i_done_res,
    input  logic [1:0]                     i_status,
    input  logic                           i_last_of_run,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_cells_seen,
    output int                             o_rows_seen,
    output int                             o_files_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import csvs_pkg::*;

    typedef enum logic [1:0] {
        LINE_START  = 2'd0,
        LINE_SKIP   = 2'd1,
        LINE_HEADER = 2'd2,
        LINE_DATA   = 2'd3
    } t_line_phase;

    typedef struct packed {
        logic [7:0]           out_byte;
        logic                 has_byte;
        logic                 end_of_cell;
        logic                 end_of_row;
        logic                 header_row;
        logic [LINE_BITS-1:0] line_number;
        logic                 done_res;
        logic [1:0]           status;
        logic                 last_of_run;
    } t_cell_result;

    // splitter copy
    logic [7:0]           delim_reg;
    logic [7:0]           comment_reg;
    t_line_phase          line_phase;
    logic                 in_quotes;
    logic                 quote_pending;
    logic                 cell_has_content;
    logic [7:0]           held_ws [SPACE_DEPTH];
    int                   held_cnt;
    logic [1:0]           bom_pos;
    logic                 at_file_start;
    logic                 header_seen;
    logic [LINE_BITS-1:0] lines_done;
    logic                 overflow_seen;

    t_cell_result expected_q[$];
    int           step_results;
    int           fail_total;
    int           cells_total;
    int           rows_total;
    int           files_total;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    task automatic emit(input logic [7:0] b, input logic has, input logic eoc,
                        input logic eor, input logic done, input logic [1:0] st);
        t_cell_result r;
        r.out_byte    = b;
        r.has_byte    = has;
        r.end_of_cell = eoc;
        r.end_of_row  = eor;
        r.header_row  = !done && (line_phase == LINE_HEADER);
        if (done)
            r.line_number = '0;
        else if (lines_done != {LINE_BITS{1'b1}})
            r.line_number = lines_done + 1'b1;
        else
            r.line_number = lines_done;
        r.done_res    = done;
        r.status      = st;
        r.last_of_run = 1'b0;
        expected_q.insert(expected_q.size(), r);
        step_results++;
    endtask

    task automatic clear_line();
        in_quotes        = 1'b0;
        quote_pending    = 1'b0;
        cell_has_content = 1'b0;
        held_cnt         = 0;
        line_phase       = LINE_START;
    endtask

    task automatic clear_file();
        clear_line();
        bom_pos       = 2'd0;
        at_file_start = 1'b1;
        header_seen   = 1'b0;
        lines_done    = '0;
        overflow_seen = 1'b0;
    endtask

    task automatic put_content(input logic [7:0] c);
        logic [7:0] v;
        int         i;
        v = c;
        if (is_blank(v)) begin
            if (!cell_has_content) return;
            // hold trailing whitespace until more content shows up
            if (held_cnt < SPACE_DEPTH) begin
                held_ws[held_cnt] = v;
                held_cnt++;
            end else begin
                overflow_seen = 1'b1;
            end
            return;
        end
        for (i = 0; i < held_cnt; i++)
            emit(held_ws[i], 1'b1, 1'b0, 1'b0, 1'b0, STATUS_OK);
        held_cnt         = 0;
        cell_has_content = 1'b1;
        if ((line_phase == LINE_HEADER) && (v >= 8'h41) && (v <= 8'h5A))
            v = v + 8'h20;
        emit(v, 1'b1, 1'b0, 1'b0, 1'b0, STATUS_OK);
    endtask

    task automatic close_line();
        if ((line_phase == LINE_HEADER) || (line_phase == LINE_DATA))
            emit(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, STATUS_OK);
        clear_line();
    endtask

    task automatic feed(input logic [7:0] c);
        if (c == LINE_END) begin
            close_line();
            if (lines_done != {LINE_BITS{1'b1}}) lines_done = lines_done + 1'b1;
            return;
        end
        if (line_phase == LINE_SKIP) return;
        if (line_phase == LINE_START) begin
            if (is_blank(c) && (c != delim_reg)) return;
            if (c == comment_reg) begin
                line_phase = LINE_SKIP;
                return;
            end
            line_phase  = header_seen ? LINE_DATA : LINE_HEADER;
            header_seen = 1'b1;
        end
        if (in_quotes) begin
            if (quote_pending) begin
                quote_pending = 1'b0;
                if (c == QUOTE_CH) begin
                    put_content(c);
                    return;
                end
                in_quotes = 1'b0;
            end else if (c == QUOTE_CH) begin
                quote_pending = 1'b1;
                return;
            end else begin
                put_content(c);
                return;
            end
        end
        if (c == QUOTE_CH) begin
            in_quotes = 1'b1;
            return;
        end
        if (c == delim_reg) begin
            held_cnt         = 0;
            cell_has_content = 1'b0;
            emit(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, STATUS_OK);
            return;
        end
        put_content(c);
    endtask

    // replay a broken byte order mark prefix as ordinary bytes
    task automatic release_bom();
        logic [1:0] held;
        held          = bom_pos;
        at_file_start = 1'b0;
        bom_pos       = 2'd0;
        if (held >= 2'd1) feed(BOM_0);
        if (held >= 2'd2) feed(BOM_1);
    endtask

    task automatic predict(input t_kind k, input logic [7:0] b);
        t_cell_result tail;
        logic [1:0]   st;
        step_results = 0;
        if (k == KIND_DATA) begin
            if (at_file_start) begin
                if ((bom_pos == 2'd0) && (b == BOM_0)) begin
                    bom_pos = 2'd1;
                    return;
                end
                if ((bom_pos == 2'd1) && (b == BOM_1)) begin
                    bom_pos = 2'd2;
                    return;
                end
                if ((bom_pos == 2'd2) && (b == BOM_2)) begin
                    bom_pos       = 2'd0;
                    at_file_start = 1'b0;
                    return;
                end
                release_bom();
            end
            feed(b);
        end else begin
            if (at_file_start) release_bom();
            close_line();
            if (!header_seen)
                st = STATUS_NO_HEADER;
            else if (overflow_seen)
                st = STATUS_OVERFLOW;
            else
                st = STATUS_OK;
            emit(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, st);
            clear_file();
        end
        if (step_results > 0) begin
            tail = expected_q[expected_q.size() - 1];
            tail.last_of_run = 1'b1;
            expected_q[expected_q.size() - 1] = tail;
        end
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_total++;
        end
    endtask

    task automatic compare_result();
        t_cell_result want;
        if (expected_q.size() == 0) begin
            $error("result with nothing expected: out_byte %0h, done_res %0b",
                   i_out_byte, i_done_res);
            fail_total++;
            return;
        end
        want = expected_q.pop_front();
        check_field("out_byte",    want.out_byte,    i_out_byte);
        check_field("has_byte",    want.has_byte,    i_has_byte);
        check_field("end_of_cell", want.end_of_cell, i_end_of_cell);
        check_field("end_of_row",  want.end_of_row,  i_end_of_row);
        check_field("header_row",  want.header_row,  i_header_row);
        check_field("line_number", want.line_number, i_line_number);
        check_field("done_res",    want.done_res,    i_done_res);
        check_field("status",      want.status,      i_status);
        check_field("last_of_run", want.last_of_run, i_last_of_run);
        if (want.end_of_cell) cells_total++;
        if (want.end_of_row) rows_total++;
        if (want.done_res) files_total++;
    endtask

    initial begin
        fail_total  = 0;
        cells_total = 0;
        rows_total  = 0;
        files_total = 0;
        delim_reg   = DELIM_RESET;
        comment_reg = COMMENT_RESET;
        clear_file();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            delim_reg   = DELIM_RESET;
            comment_reg = COMMENT_RESET;
            clear_file();
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DELIMITER)
                    delim_reg = i_cfg_data;
                else
                    comment_reg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) predict(t_kind'(i_kind), i_data_byte);
            if (i_out_valid && i_out_ready) compare_result();
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_total;
        o_cells_seen <= cells_total;
        o_rows_seen  <= rows_total;
        o_files_seen <= files_total;
    end

endmodule

FILE: tb/csv_record_splitter_unit_tb.sv
// ----------------------------------------------------------------------------
// csv_record_splitter_unit_tb
// Drives the CSV record splitter with a directed file set, then random files
// (byte order marks, comments, blank lines, quoted cells, long whitespace
// runs) under several delimiter and comment settings, with bursty input and
// a stalling receiver. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module csv_record_splitter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csvs_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 100;
    localparam int NUM_SETTINGS  = 8;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_stim;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic                 cfg_index   = CFG_DELIMITER;
    logic [7:0]           cfg_data    = 8'h00;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    t_kind                in_kind     = KIND_DATA;
    logic [7:0]           in_byte     = 8'h00;
    logic                 out_valid;
    logic                 out_ready   = 1'b1;
    logic [7:0]           res_byte;
    logic                 res_has_byte;
    logic                 res_eoc;
    logic                 res_eor;
    logic                 res_header;
    logic [LINE_BITS-1:0] res_line;
    logic                 res_done;
    logic [1:0]           res_status;
    logic                 res_last;

    int fail_count;
    int pending;
    int cells_seen;
    int rows_seen;
    int files_seen;

    logic       calm        = 1'b0;
    int         stall_left  = 0;
    int         run_left    = 0;
    int         idle_cycles = 0;
    int         items_sent  = 0;
    logic [7:0] cur_delim   = DELIM_RESET;
    logic [7:0] cur_comment = COMMENT_RESET;
    t_stim      stim_q[$];

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    csv_record_splitter_unit DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_kind        (in_kind),
        .i_data_byte   (in_byte),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_byte    (res_byte),
        .o_has_byte    (res_has_byte),
        .o_end_of_cell (res_eoc),
        .o_end_of_row  (res_eor),
        .o_header_row  (res_header),
        .o_line_number (res_line),
        .o_done_res    (res_done),
        .o_status      (res_status),
        .o_last_of_run (res_last)
    );

    csv_record_splitter_checker cell_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_kind        (in_kind),
        .i_data_byte   (in_byte),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_byte    (res_byte),
        .i_has_byte    (res_has_byte),
        .i_end_of_cell (res_eoc),
        .i_end_of_row  (res_eor),
        .i_header_row  (res_header),
        .i_line_number (res_line),
        .i_done_res    (res_done),
        .i_status      (res_status),
        .i_last_of_run (res_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_cells_seen  (cells_seen),
        .o_rows_seen   (rows_seen),
        .o_files_seen  (files_seen)
    );

    // receiver: runs of ready broken by short and occasional long stalls
    always @(posedge clk) begin
        if (!rst_n || calm) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (run_left > 0) begin
            out_ready <= 1'b1;
            run_left  <= run_left - 1;
        end else begin
            out_ready  <= 1'b1;
            run_left   <= $urandom_range(12, 1);
            stall_left <= ($urandom_range(3, 0) == 0) ? $urandom_range(12, 4)
                                                       : $urandom_range(2, 0);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [7:0] ws_byte();
        case ($urandom_range(4, 0))
            0:       return 8'h09;
            1:       return 8'h0B;
            2:       return 8'h0C;
            3:       return 8'h0D;
            default: return 8'h20;
        endcase
    endfunction

    function automatic logic [7:0] cell_byte();
        case ($urandom_range(11, 0))
            0, 1, 2: return 8'h41 + 8'($urandom_range(25, 0));
            3, 4:    return 8'h61 + 8'($urandom_range(25, 0));
            5:       return 8'h30 + 8'($urandom_range(9, 0));
            6:       return 8'h20;
            7:       return ws_byte();
            8:       return QUOTE_CH;
            9:       return cur_delim;
            10:      return 8'($urandom_range(255, 0));
            default: begin
                // bytes at and just outside the edges of the case-folding range
                case ($urandom_range(3, 0))
                    0:       return 8'h40;
                    1:       return 8'h41;
                    2:       return 8'h5A;
                    default: return 8'h5B;
                endcase
            end
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] b);
        t_stim s;
        s.kind = KIND_DATA;
        s.data = b;
        stim_q.insert(stim_q.size(), s);
    endtask

    task automatic add_eoi();
        t_stim s;
        s.kind = KIND_EOI;
        s.data = 8'($urandom_range(255, 0));
        stim_q.insert(stim_q.size(), s);
    endtask

    task automatic add_cell();
        int style;
        style = $urandom_range(9, 0);
        repeat ($urandom_range(2, 0)) add_byte(ws_byte());
        if (style < 3) begin
            add_byte(QUOTE_CH);
            repeat ($urandom_range(4, 0)) begin
                if ($urandom_range(4, 0) == 0) begin
                    add_byte(QUOTE_CH);
                    add_byte(QUOTE_CH);
                end else begin
                    add_byte(cell_byte());
                end
            end
            // now and then leave the span open to the line end
            if ($urandom_range(5, 0) != 0) add_byte(QUOTE_CH);
        end else begin
            repeat ($urandom_range(4, 1)) add_byte(cell_byte());
        end
        if (style == 9) begin
            // long run around the whitespace buffer depth, then more content
            repeat ($urandom_range(20, 14)) add_byte(ws_byte());
            add_byte(8'h41 + 8'($urandom_range(25, 0)));
        end
        repeat ($urandom_range(2, 0)) add_byte(ws_byte());
    endtask

    task automatic add_line(input logic no_lf);
        int sel;
        int ncells;
        int c;
        sel = $urandom_range(9, 0);
        if (sel == 0) begin
            repeat ($urandom_range(1, 0)) add_byte(ws_byte());
            add_byte(cur_comment);
            repeat ($urandom_range(3, 0)) add_byte(cell_byte());
        end else if (sel == 1) begin
            repeat ($urandom_range(3, 0)) add_byte(ws_byte());
        end else if (sel == 2) begin
            repeat ($urandom_range(5, 1)) add_byte(8'($urandom_range(255, 0)));
        end else begin
            ncells = $urandom_range(3, 1);
            for (c = 0; c < ncells; c++) begin
                if (c > 0) add_byte(cur_delim);
                add_cell();
            end
            if ($urandom_range(3, 0) == 0) add_byte(8'h0D);
        end
        if (!no_lf) add_byte(LINE_END);
    endtask

    task automatic add_file();
        int nlines;
        int l;
        case ($urandom_range(5, 0))
            0: begin
                add_byte(BOM_0);
                add_byte(BOM_1);
                add_byte(BOM_2);
            end
            1: add_byte(BOM_0);
            2: begin
                add_byte(BOM_0);
                add_byte(BOM_1);
            end
            default: ;
        endcase
        nlines = $urandom_range(2, 1);
        for (l = 0; l < nlines; l++)
            add_line((l == nlines - 1) && ($urandom_range(2, 0) == 0));
        add_eoi();
    endtask

    task automatic wait_drain();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // drain, then let items that cause no result work through the block
    task automatic wait_idle();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] delim, input logic [7:0] cmark);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DELIMITER;
        cfg_data  <= delim;
        @(posedge clk);
        cfg_index <= CFG_COMMENT_MARK;
        cfg_data  <= cmark;
        @(posedge clk);
        cfg_we      <= 1'b0;
        cur_delim   = delim;
        cur_comment = cmark;
    endtask

    task automatic push_items(input int pause_at);
        t_stim it;
        int    idx;
        int    burst_left;
        burst_left = $urandom_range(8, 1);
        for (idx = 0; idx < stim_q.size(); idx++) begin
            if (idx == pause_at) begin
                // hold off until every outstanding result has come back
                in_valid <= 1'b0;
                wait_drain();
            end
            it = stim_q[idx];
            in_valid <= 1'b1;
            in_kind  <= it.kind;
            in_byte  <= it.data;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            items_sent++;
            if (!calm && (burst_left == 0)) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(7, 1)) @(posedge clk);
                burst_left = $urandom_range(12, 1);
            end else if (burst_left > 0) begin
                burst_left--;
            end
        end
        in_valid <= 1'b0;
        stim_q.delete();
    endtask

    function automatic logic [15:0] setting_for(input int ph);
        case (ph)
            0:       return {DELIM_RESET, COMMENT_RESET};
            1:       return {8'h09, 8'h3B};   // tab delimiter
            2:       return {8'h00, 8'hFF};
            3:       return {8'hFF, 8'h00};
            4:       return {8'h3B, 8'h3B};   // comment mark equals delimiter
            5:       return {LINE_END, COMMENT_RESET};
            6:       return {QUOTE_CH, LINE_END};
            default: return {8'h20, COMMENT_RESET};
        endcase
    endfunction

    initial begin
        int          ph;
        logic [15:0] setting;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_config(DELIM_RESET, COMMENT_RESET);

        // header with full byte order mark, doubled quote, unclosed quote, CR
        add_byte(BOM_0); add_byte(BOM_1); add_byte(BOM_2);
        add_byte("N"); add_byte("a"); add_byte(",");
        add_byte(QUOTE_CH); add_byte("q"); add_byte(QUOTE_CH); add_byte(QUOTE_CH);
        add_byte(QUOTE_CH); add_byte(",");
        add_byte(QUOTE_CH); add_byte("x"); add_byte(8'h20); add_byte(8'h0D);
        add_byte(LINE_END);
        // comment line, blank line, last line without line end
        add_byte("#"); add_byte("z"); add_byte(LINE_END);
        add_byte(8'h20); add_byte(LINE_END);
        add_byte(8'h00); add_byte(8'hFF); add_byte(8'h20); add_byte("c");
        add_eoi();
        // broken byte order mark released at end of input, then an empty file
        add_byte(BOM_0);
        add_eoi();
        add_eoi();
        push_items(-1);

        for (ph = 0; ph < NUM_SETTINGS; ph++) begin
            wait_idle();
            setting = setting_for(ph);
            set_config(setting[15:8], setting[7:0]);
            calm <= (ph % 3 == 1);
            add_file();
            push_items((ph % 2 == 0) ? stim_q.size() / 2 : -1);
        end
        wait_idle();

        $display("covered %0d input transfers under %0d register settings plus directed files",
                 items_sent, NUM_SETTINGS);
        $display("checked %0d cells in %0d rows across %0d files",
                 cells_seen, rows_seen, files_seen);
        if ((fail_count == 0) && (pending == 0))
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
